@@ design/pnn_pkg.sv @@
// ----------------------------------------------------------------------------
// pnn_pkg
// Shared types and constants for the polygon Newell normal block.
// ----------------------------------------------------------------------------
package pnn_pkg;
	localparam int COORD_BITS = 16;
	localparam int MAX_VERTS  = 256;
	localparam int CNT_BITS   = $clog2(MAX_VERTS + 1);
	localparam int ACC_BITS   = 48;
	localparam int ID_BITS    = 24;
	localparam int PID_BITS   = 25;
	localparam int OUT_BITS   = 16;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [ACC_BITS-1:0]   acc_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EDGE,
		ST_CLOSE1,
		ST_CLOSE2,
		ST_NORM,
		ST_SQRT,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		EDGE_BACK_PREV,
		EDGE_BACK_FIRST,
		EDGE_PREV_FIRST
	} edge_sel_t;

	typedef struct packed {
		logic      capture;    // take a vertex from the input
		logic      edge_go;    // accumulate one edge
		edge_sel_t edge_sel;
		logic      norm_go;    // one normalize step
		logic      sqrt_start;
		logic      sqrt_step;
		logic      div_start;
		logic      div_step;
		logic      clear;
	} pnn_cmd_t;

	typedef struct packed {
		logic kept;        // vertex on the input would be kept
		logic close_dup;   // last kept id repeats the first
		logic two_plus;    // kept_count >= 2
		logic norm_done;
		logic sqrt_done;
		logic div_done;
		logic degen;
	} pnn_stat_t;
endpackage

@@ design/pnn_ctrl.sv @@
// ----------------------------------------------------------------------------
// pnn_ctrl
// Controller: sequences vertex capture, edge sums, normalization, square root, divide and output.
// ----------------------------------------------------------------------------
module pnn_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic              in_last,
	input  logic              out_fire,
	input  pnn_pkg::pnn_stat_t stat,
	output pnn_pkg::pnn_cmd_t  cmd,
	output logic              in_ready,
	output logic              out_valid
);
	import pnn_pkg::*;

	state_t state_q, state_d;
	logic   last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire) last_q <= in_last;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_fire) state_d = ST_EDGE;
			ST_EDGE: begin
				if (!last_q) state_d = ST_IDLE;
				else if (!stat.two_plus) state_d = ST_NORM;
				else if (stat.close_dup) state_d = ST_CLOSE2;
				else state_d = ST_CLOSE1;
			end
			ST_CLOSE1: state_d = ST_CLOSE2;
			ST_CLOSE2: state_d = ST_NORM;
			ST_NORM: begin
				if (stat.degen) state_d = ST_OUT;
				else if (stat.norm_done) state_d = ST_SQRT;
			end
			ST_SQRT:   if (stat.sqrt_done) state_d = ST_DIV;
			ST_DIV:    if (stat.div_done) state_d = ST_OUT;
			ST_OUT:    if (out_fire) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.edge_sel = EDGE_BACK_PREV;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_fire;
				// edge back->prev is added from the old registers as the vertex lands
				cmd.edge_go  = in_fire && stat.kept && stat.two_plus;
				cmd.edge_sel = EDGE_BACK_PREV;
			end
			ST_CLOSE1: begin
				cmd.edge_go  = 1'b1;
				cmd.edge_sel = EDGE_BACK_PREV;
			end
			ST_CLOSE2: begin
				cmd.edge_go  = 1'b1;
				cmd.edge_sel = stat.close_dup ? EDGE_BACK_FIRST : EDGE_PREV_FIRST;
			end
			ST_NORM: begin
				cmd.norm_go    = 1'b1;
				cmd.sqrt_start = stat.norm_done;
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				cmd.div_start = stat.sqrt_done;
			end
			ST_DIV:  cmd.div_step = 1'b1;
			ST_OUT: begin
				out_valid = 1'b1;
				cmd.clear = out_fire;
			end
			default: ;
		endcase
	end
endmodule

@@ design/pnn_dp.sv @@
// ----------------------------------------------------------------------------
// pnn_dp
// Datapath: vertex registers, saturating Newell sums, normalize, sqrt, divide.
// ----------------------------------------------------------------------------
module pnn_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  pnn_pkg::pnn_cmd_t                     cmd,
	input  logic [pnn_pkg::ID_BITS-1:0]           point_count,
	input  logic [pnn_pkg::PID_BITS-1:0]          point_id,
	input  pnn_pkg::coord_t                       coord_x,
	input  pnn_pkg::coord_t                       coord_y,
	input  pnn_pkg::coord_t                       coord_z,
	output pnn_pkg::pnn_stat_t                    stat,
	output logic signed [pnn_pkg::OUT_BITS-1:0]   normal_x,
	output logic signed [pnn_pkg::OUT_BITS-1:0]   normal_y,
	output logic signed [pnn_pkg::OUT_BITS-1:0]   normal_z
);
	import pnn_pkg::*;

	localparam int CB = COORD_BITS + 1;        // sum/difference width
	localparam int PB = 2 * CB;                // product width
	localparam logic [ACC_BITS-1:0] AMAX = {1'b0, {(ACC_BITS-1){1'b1}}};
	localparam logic [ACC_BITS-1:0] AMIN = {1'b1, {(ACC_BITS-1){1'b0}}};

	coord_t first_q [3];
	coord_t prev_q  [3];
	coord_t back_q  [3];
	logic [ID_BITS-1:0]  first_id_q, prev_id_q;
	logic [CNT_BITS-1:0] cnt_q;
	acc_t  sum_q [3];

	// vertex keep test
	logic id_ok, keep;
	assign id_ok = !point_id[PID_BITS-1] && (point_id[ID_BITS-1:0] < point_count);
	assign keep  = id_ok && (cnt_q < CNT_BITS'(MAX_VERTS))
		&& !((cnt_q != '0) && (point_id[ID_BITS-1:0] == prev_id_q));

	// edge selection
	coord_t ea [3];
	coord_t eb [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ea[i] = back_q[i];
			eb[i] = prev_q[i];
		end
		unique case (cmd.edge_sel)
			EDGE_BACK_PREV: ;
			EDGE_BACK_FIRST: for (int i = 0; i < 3; i++) eb[i] = first_q[i];
			EDGE_PREV_FIRST: for (int i = 0; i < 3; i++) begin
				ea[i] = prev_q[i];
				eb[i] = first_q[i];
			end
			default: ;
		endcase
	end

	// x: dy*sz, y: dz*sx, z: dx*sy  (products fit 34 bits, never saturate)
	logic signed [CB-1:0] dif [3];
	logic signed [CB-1:0] sm  [3];
	logic signed [PB-1:0] prod [3];
	acc_t nsum [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dif[i] = CB'(ea[i]) - CB'(eb[i]);
			sm[i]  = CB'(ea[i]) + CB'(eb[i]);
		end
		prod[0] = dif[1] * sm[2];
		prod[1] = dif[2] * sm[0];
		prod[2] = dif[0] * sm[1];
		for (int i = 0; i < 3; i++) begin
			logic signed [ACC_BITS:0] s;
			s = {sum_q[i][ACC_BITS-1], sum_q[i]} + (ACC_BITS+1)'(prod[i]);
			if (s[ACC_BITS] != s[ACC_BITS-1])
				nsum[i] = s[ACC_BITS] ? AMIN : AMAX;
			else
				nsum[i] = s[ACC_BITS-1:0];
		end
	end

	// normalization registers
	logic [ACC_BITS-1:0] mag_q [3];
	logic [2:0]          neg_q;
	logic                norm_ld_q;
	logic [ACC_BITS-1:0] maxm;
	always_comb begin
		maxm = mag_q[0];
		if (mag_q[1] > maxm) maxm = mag_q[1];
		if (mag_q[2] > maxm) maxm = mag_q[2];
	end
	logic too_big, too_small;
	assign too_big   = maxm[ACC_BITS-1:30] != '0;
	assign too_small = !maxm[29];

	// sqrt (one result bit per cycle) on 62-bit sum of squares
	localparam int QB = 64;
	logic [QB-1:0] q_q, r_q, bit_q;
	logic [1:0]    sq_ph_q;          // sum-of-squares accumulation phase
	logic          sq_busy_q;
	logic [30:0]   m30 [3];
	always_comb for (int i = 0; i < 3; i++) m30[i] = mag_q[i][30:0];

	logic [QB-1:0] sqr;
	always_comb begin
		unique case (sq_ph_q)
			2'd0:    sqr = QB'(m30[0]) * QB'(m30[0]);
			2'd1:    sqr = QB'(m30[1]) * QB'(m30[1]);
			default: sqr = QB'(m30[2]) * QB'(m30[2]);
		endcase
	end

	// divider: restoring, one quotient bit per cycle, three components in turn
	localparam int NB = 46;           // mag*32768 + len/2 < 2^46
	logic [NB-1:0] num_q, rem_q, quo_q;
	logic [5:0]    dcnt_q;
	logic [1:0]    comp_q;
	logic [31:0]   len_q;
	logic signed [OUT_BITS-1:0] res_q [3];
	logic          div_done_q;

	logic [NB:0]   rtry;
	assign rtry = {rem_q, num_q[NB-1]} - (NB+1)'(len_q);

	logic [NB-1:0] mag_sel;
	always_comb begin
		unique case (comp_q)
			2'd0:    mag_sel = NB'(mag_q[0][30:0]) << 15;
			2'd1:    mag_sel = NB'(mag_q[1][30:0]) << 15;
			default: mag_sel = NB'(mag_q[2][30:0]) << 15;
		endcase
	end

	logic [OUT_BITS-1:0] sat_pos, sat_neg;
	always_comb begin
		logic [NB-1:0] qf;
		qf = {quo_q[NB-2:0], ~rtry[NB]};
		sat_pos = (qf > NB'(32767)) ? OUT_BITS'(32767) : qf[OUT_BITS-1:0];
		sat_neg = (qf > NB'(32768)) ? OUT_BITS'(32768) : qf[OUT_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			first_id_q <= '0;
			prev_id_q  <= '0;
			norm_ld_q  <= 1'b0;
			sq_busy_q  <= 1'b0;
			div_done_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				first_q[i] <= '0;
				prev_q[i]  <= '0;
				back_q[i]  <= '0;
				sum_q[i]   <= '0;
			end
		end else begin
			if (cmd.capture) begin
				norm_ld_q <= 1'b0;
				if (keep) begin
					if (cnt_q == '0) begin
						first_q[0] <= coord_x;
						first_q[1] <= coord_y;
						first_q[2] <= coord_z;
						first_id_q <= point_id[ID_BITS-1:0];
					end else begin
						for (int i = 0; i < 3; i++) back_q[i] <= prev_q[i];
					end
					prev_q[0] <= coord_x;
					prev_q[1] <= coord_y;
					prev_q[2] <= coord_z;
					prev_id_q <= point_id[ID_BITS-1:0];
					cnt_q     <= cnt_q + 1'b1;
				end
			end
			// the capture-cycle edge reads back/prev before they move
			if (cmd.edge_go) for (int i = 0; i < 3; i++) sum_q[i] <= nsum[i];
			if (cmd.norm_go) norm_ld_q <= 1'b1;
			if (cmd.sqrt_start) sq_busy_q <= 1'b1;
			if (cmd.div_start) begin
				sq_busy_q  <= 1'b0;
				div_done_q <= 1'b0;
			end
			if (cmd.div_step && dcnt_q == 6'd0 && comp_q == 2'd2) div_done_q <= 1'b1;
			if (cmd.clear) begin
				cnt_q      <= '0;
				first_id_q <= '0;
				prev_id_q  <= '0;
				norm_ld_q  <= 1'b0;
				div_done_q <= 1'b0;
				for (int i = 0; i < 3; i++) begin
					first_q[i] <= '0;
					prev_q[i]  <= '0;
					back_q[i]  <= '0;
					sum_q[i]   <= '0;
				end
			end
		end
	end

	// payload-only registers
	always_ff @(posedge clk) begin
		if (cmd.norm_go) begin
			if (!norm_ld_q) begin
				for (int i = 0; i < 3; i++) begin
					mag_q[i] <= sum_q[i][ACC_BITS-1] ? (ACC_BITS)'(-sum_q[i]) : sum_q[i];
					neg_q[i] <= sum_q[i][ACC_BITS-1];
				end
			end else if (too_big) begin
				for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
			end else if (too_small) begin
				for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
			end
		end
		if (cmd.sqrt_start) begin
			q_q     <= '0;
			sq_ph_q <= 2'd0;
			r_q     <= '0;
			bit_q   <= QB'(1) << 62;
		end else if (cmd.sqrt_step) begin
			if (sq_ph_q != 2'd3) begin
				q_q     <= q_q + sqr;
				sq_ph_q <= sq_ph_q + 2'd1;
			end else if (bit_q != '0) begin
				if (q_q >= r_q + bit_q) begin
					q_q <= q_q - (r_q + bit_q);
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
		end
		if (cmd.div_start) begin
			len_q  <= r_q[31:0];
			comp_q <= 2'd0;
			dcnt_q <= 6'd63;   // load cycle marker
		end else if (cmd.div_step) begin
			if (dcnt_q == 6'd63) begin
				num_q  <= mag_sel + NB'(len_q >> 1);
				rem_q  <= '0;
				quo_q  <= '0;
				dcnt_q <= 6'(NB - 1);
			end else begin
				num_q <= num_q << 1;
				quo_q <= {quo_q[NB-2:0], ~rtry[NB]};
				rem_q <= rtry[NB] ? {rem_q[NB-2:0], num_q[NB-1]} : rtry[NB-1:0];
				if (dcnt_q == 6'd0) begin
					res_q[comp_q] <= neg_q[comp_q] ? -$signed(sat_neg) : $signed(sat_pos);
					comp_q <= comp_q + 2'd1;
					dcnt_q <= 6'd63;
				end else begin
					dcnt_q <= dcnt_q - 6'd1;
				end
			end
		end
		if (cmd.clear) for (int i = 0; i < 3; i++) res_q[i] <= '0;
	end

	logic [CNT_BITS-1:0] n_eff;
	assign n_eff = (cnt_q >= CNT_BITS'(2) && prev_id_q == first_id_q) ? cnt_q - 1'b1 : cnt_q;

	logic degen_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) degen_q <= 1'b0;
		else if (cmd.norm_go && !norm_ld_q)
			degen_q <= (n_eff < CNT_BITS'(3))
				|| (sum_q[0] == '0 && sum_q[1] == '0 && sum_q[2] == '0);
		else if (cmd.clear) degen_q <= 1'b0;
	end

	assign stat.kept      = keep;
	assign stat.close_dup = prev_id_q == first_id_q;
	assign stat.two_plus  = cnt_q >= CNT_BITS'(2);
	assign stat.norm_done = norm_ld_q && !too_big && !too_small;
	assign stat.sqrt_done = sq_busy_q && sq_ph_q == 2'd3 && bit_q == '0;
	assign stat.div_done  = div_done_q;
	assign stat.degen     = norm_ld_q && degen_q;

	assign normal_x = degen_q ? '0 : res_q[0];
	assign normal_y = degen_q ? '0 : res_q[1];
	assign normal_z = degen_q ? '0 : res_q[2];
endmodule

@@ design/polygon_newell_normal_top.sv @@
// ----------------------------------------------------------------------------
// polygon_newell_normal_top
// Newell normal of a polygon streamed one vertex per transaction.
// ----------------------------------------------------------------------------
// Input stream s_axis: one vertex per transaction, tlast marks the polygon's
// final vertex. Output stream m_axis: one unit normal (Q1.15) per polygon with
// tuser = degenerate. Config: cfg_we/cfg_data write point_count.
// Each vertex is captured with its saturating edge add, and the controller then
// checks for the end of the polygon before it takes the next vertex.
// After the final vertex the closing edges are added; then the normalize shifter,
// the sum of squares and bit-serial square root and three restoring divides, one
// per component, run in turn before m_axis_tvalid. A degenerate polygon skips
// the shifter, square root and divides. Reset clears the vertices, count and
// Newell sums (not the payload-only normalize, sqrt and divide registers) and
// sets point_count to its maximum.
// While the result waits for m_axis_tready no new vertex is taken; the
// polygon state clears when the result transaction completes.
// ----------------------------------------------------------------------------
module polygon_newell_normal_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [23:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,  // point_id[24:0], coord_x, coord_y, coord_z, pad
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // normal_x, normal_y, normal_z
	output logic        m_axis_tuser   // degenerate
);
	import pnn_pkg::*;

	logic [ID_BITS-1:0] point_count_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) point_count_q <= '1;
		else if (cfg_we) point_count_q <= cfg_data;
	end

	pnn_cmd_t  cmd;
	pnn_stat_t stat;
	logic in_fire, out_fire;
	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;

	pnn_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .in_last(s_axis_tlast), .out_fire,
		.stat, .cmd, .in_ready(s_axis_tready), .out_valid(m_axis_tvalid)
	);

	logic signed [OUT_BITS-1:0] nx, ny, nz;
	pnn_dp u_dp (
		.clk, .arst_n, .cmd, .point_count(point_count_q),
		.point_id(s_axis_tdata[24:0]),
		.coord_x(s_axis_tdata[40:25]),
		.coord_y(s_axis_tdata[56:41]),
		.coord_z(s_axis_tdata[72:57]),
		.stat, .normal_x(nx), .normal_y(ny), .normal_z(nz)
	);

	assign m_axis_tdata = {nz, ny, nx};
	assign m_axis_tuser = stat.degen;
endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Regression for polygon_newell_normal_top. Vertices are streamed in with
// random gaps and output back-pressure. A behavioral model predicts each
// polygon's unit normal and degenerate flag, and every result is checked
// field by field in order.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pnn_pkg::*;

	localparam longint ACC_MAX = (64'sd1 <<< 47) - 1;
	localparam longint ACC_MIN = -ACC_MAX - 1;
	localparam int     DRAIN_CYCLES = 300;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct {
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic               degen;
	} normal_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [23:0] cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic        m_axis_tuser;

	polygon_newell_normal_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// model state
	logic [23:0] pc_reg;
	longint      fp[3], pp[3], bp[3];
	logic [23:0] f_id, p_id;
	longint      nsum[3];
	int          kept;

	normal_t     pending_normals[$];
	int          fails = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          hold_left = 0;
	longint      cycles = 0;

	function automatic longint sat48(longint v);
		if (v > ACC_MAX) return ACC_MAX;
		if (v < ACC_MIN) return ACC_MIN;
		return v;
	endfunction

	function automatic longint unsigned mag(longint v);
		return v < 0 ? longint'(-v) : v;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	task automatic add_edge(input longint a[3], input longint b[3]);
		nsum[0] = sat48(nsum[0] + sat48((a[1] - b[1]) * (a[2] + b[2])));
		nsum[1] = sat48(nsum[1] + sat48((a[2] - b[2]) * (a[0] + b[0])));
		nsum[2] = sat48(nsum[2] + sat48((a[0] - b[0]) * (a[1] + b[1])));
	endtask

	task automatic clear_polygon();
		for (int i = 0; i < 3; i++) begin
			fp[i] = 0; pp[i] = 0; bp[i] = 0; nsum[i] = 0;
		end
		f_id = 0;
		p_id = 0;
		kept = 0;
	endtask

	// advance the model by one accepted vertex; queue a normal on tlast
	task automatic predict_vertex(input logic [24:0] pid, input logic signed [15:0] x,
			input logic signed [15:0] y, input logic signed [15:0] z, input logic last);
		longint          w[3];
		longint unsigned m[3], maxm, q, len, r;
		int              n;
		logic            id_ok;
		normal_t         res;
		w[0] = x; w[1] = y; w[2] = z;
		id_ok = !pid[24] && (pid[23:0] < pc_reg);
		if (id_ok && kept < MAX_VERTS && !(kept > 0 && pid[23:0] == p_id)) begin
			if (kept >= 2) add_edge(bp, pp);
			if (kept == 0) begin
				fp = w;
				f_id = pid[23:0];
			end else begin
				bp = pp;
			end
			pp = w;
			p_id = pid[23:0];
			kept++;
		end
		if (!last) return;
		n = kept;
		if (n >= 2 && p_id == f_id) begin
			n--;
			add_edge(bp, fp);
		end else if (n >= 2) begin
			add_edge(bp, pp);
			add_edge(pp, fp);
		end
		for (int i = 0; i < 3; i++) m[i] = mag(nsum[i]);
		maxm = m[0];
		if (m[1] > maxm) maxm = m[1];
		if (m[2] > maxm) maxm = m[2];
		res = '{16'sd0, 16'sd0, 16'sd0, 1'b1};
		if (n >= 3 && maxm != 0) begin
			while (maxm >= (64'd1 << 30)) begin
				maxm = maxm >> 1;
				for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
			end
			while (maxm < (64'd1 << 29)) begin
				maxm = maxm << 1;
				for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
			end
			q = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
			len = int_sqrt(q);
			res.degen = 1'b0;
			for (int i = 0; i < 3; i++) begin
				logic signed [15:0] v;
				r = (m[i] * 32768 + len / 2) / len;
				if (nsum[i] < 0) v = (r >= 32768) ? -16'sd32768 : -$signed(16'(r));
				else             v = (r > 32767) ? 16'sd32767 : 16'(r);
				if (i == 0) res.nx = v;
				else if (i == 1) res.ny = v;
				else res.nz = v;
			end
		end
		pending_normals.insert(pending_normals.size(), res);
		clear_polygon();
	endtask

	// one vertex transaction; tvalid stays up on return
	task automatic send_vertex(input logic [24:0] pid, input logic signed [15:0] x,
			input logic signed [15:0] y, input logic signed [15:0] z, input logic last);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, z, y, x, pid};
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		predict_vertex(pid, x, y, z, last);
		@(negedge clk);
	endtask

	task automatic stop_sending();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (pending_normals.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_point_count(input logic [23:0] v);
		stop_sending();
		wait_drained();
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we   <= 1'b0;
		pc_reg = v;
	endtask

	function automatic logic signed [15:0] rand_coord();
		if ($urandom_range(1, 0)) return 16'($urandom);
		return 16'($signed($urandom_range(4000, 0)) - 2000);
	endfunction

	function automatic logic [24:0] rand_good_id();
		return {1'b0, 24'($urandom_range(int'(pc_reg) - 1, 0))};
	endfunction

	function automatic logic [24:0] rand_bad_id();
		if (pc_reg != 24'hFFFFFF && $urandom_range(1, 0))
			return {1'b0, 24'($urandom_range(32'hFFFFFF, int'(pc_reg)))};
		return {1'b1, 24'($urandom)};
	endfunction

	// mostly well-formed polygon with random content, some repeats, skips, closing dup
	task automatic send_polygon(input int nv);
		logic [24:0]        id, first_vid, prev_vid;
		logic signed [15:0] x, y, z, fx, fy, fz;
		int                 pick;
		for (int i = 0; i < nv; i++) begin
			pick = $urandom_range(99, 0);
			x = rand_coord(); y = rand_coord(); z = rand_coord();
			if (i > 0 && pick < 6) id = prev_vid;
			else if (pick < 11) id = rand_bad_id();
			else id = rand_good_id();
			if (i == 0) begin
				first_vid = id; fx = x; fy = y; fz = z;
			end
			if (i == nv - 1 && i > 0 && pick >= 85) begin
				id = first_vid; x = fx; y = fy; z = fz;
			end
			send_vertex(id, x, y, z, i == nv - 1);
			prev_vid = id;
		end
	endtask

	task automatic test_directed();
		// plain triangle
		send_vertex(25'd1, 16'sd0, 16'sd0, 16'sd0, 1'b0);
		send_vertex(25'd2, 16'sd256, 16'sd0, 16'sd0, 1'b0);
		send_vertex(25'd3, 16'sd0, 16'sd256, 16'sd0, 1'b1);
		// extreme coordinates, closing vertex equal to the first
		send_vertex(25'd0, 16'sh7FFF, -16'sh8000, 16'sh7FFF, 1'b0);
		send_vertex(25'd9, -16'sh8000, 16'sh7FFF, -16'sh8000, 1'b0);
		send_vertex(25'd9, 16'sd5, 16'sd5, 16'sd5, 1'b0);          // repeated id
		send_vertex(25'h1FFFFFF, 16'sd1, 16'sd2, 16'sd3, 1'b0);    // negative id
		send_vertex(25'hFFFFFF, 16'sd1, 16'sd2, 16'sd3, 1'b0);     // id at count
		send_vertex(25'h7, -16'sh8000, -16'sh8000, 16'sh7FFF, 1'b0);
		send_vertex(25'd0, 16'sh7FFF, -16'sh8000, 16'sh7FFF, 1'b1);
		// lone vertex, then two vertices
		send_vertex(25'd4, 16'sd10, 16'sd20, 16'sd30, 1'b1);
		send_vertex(25'd4, 16'sd10, 16'sd20, 16'sd30, 1'b0);
		send_vertex(25'd5, 16'sd40, 16'sd20, 16'sd30, 1'b1);
		// collinear: zero area
		send_vertex(25'd1, 16'sd0, 16'sd0, 16'sd0, 1'b0);
		send_vertex(25'd2, 16'sd100, 16'sd100, 16'sd100, 1'b0);
		send_vertex(25'd3, 16'sd200, 16'sd200, 16'sd200, 1'b1);
		// skipped last vertex still ends the polygon
		send_vertex(25'hFFFFFE, 16'sd0, 16'sd0, 16'sd0, 1'b0);
		send_vertex(25'd8, 16'sd0, -16'sd300, 16'sd700, 1'b0);
		send_vertex(25'd6, 16'sd900, 16'sd0, -16'sd50, 1'b0);
		send_vertex(25'h1000000, 16'sd1, 16'sd1, 16'sd1, 1'b1);
		// closing dup leaves two vertices: degenerate
		send_vertex(25'd1, 16'sd1, 16'sd0, 16'sd0, 1'b0);
		send_vertex(25'd2, 16'sd0, 16'sd1, 16'sd0, 1'b0);
		send_vertex(25'd1, 16'sd1, 16'sd0, 16'sd0, 1'b1);
	endtask

	task automatic test_random(input int items);
		int sent, nv;
		sent = 0;
		while (sent < items) begin
			nv = ($urandom_range(9, 0) == 0) ? $urandom_range(2, 1) : $urandom_range(8, 3);
			send_polygon(nv);
			sent += nv;
		end
	endtask

	task automatic test_vertex_overflow();
		for (int i = 0; i < MAX_VERTS + 6; i++)
			send_vertex(25'(i), rand_coord(), rand_coord(), rand_coord(),
				i == MAX_VERTS + 5);
	endtask

	task automatic test_backpressure();
		hold_left = 3000;
		for (int i = 0; i < 12; i++) send_polygon(4);
		stop_sending();
		// sender waits for every result before going on
		while (pending_normals.size() != 0) @(negedge clk);
		send_polygon(5);
	endtask

	task automatic test_point_count();
		set_point_count(24'd1);
		test_random(30);
		set_point_count(24'd12);
		test_random(80);
		set_point_count(24'd1000);
		test_random(60);
		set_point_count(24'hFFFFFF);
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		normal_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_normals.size() == 0) begin
				$display("%0t unexpected normal: %h deg %b", $realtime, m_axis_tdata,
					m_axis_tuser);
				fails++;
			end else begin
				e = pending_normals.pop_front();
				if (m_axis_tdata[15:0] !== e.nx || m_axis_tdata[31:16] !== e.ny ||
						m_axis_tdata[47:32] !== e.nz || m_axis_tuser !== e.degen) begin
					$display("%0t normal mismatch: expected %h %h %h deg %b, got %h %h %h deg %b",
						$realtime, e.nx, e.ny, e.nz, e.degen, m_axis_tdata[15:0],
						m_axis_tdata[31:16], m_axis_tdata[47:32], m_axis_tuser);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("polygon_newell_normal_top regression: fail");
			$finish;
		end
	end

	initial begin
		pc_reg = 24'hFFFFFF;
		clear_polygon();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_idle_pct = 16; recv_idle_pct = 73;
		test_directed();
		test_random(200);
		send_idle_pct = 73; recv_idle_pct = 16;
		test_random(200);
		test_vertex_overflow();
		send_idle_pct = 0; recv_idle_pct = 0;
		test_random(100);
		test_backpressure();
		test_point_count();
		send_idle_pct = 16; recv_idle_pct = 16;
		test_random(60);

		stop_sending();
		wait_drained();
		if (fails == 0)
			$display("polygon_newell_normal_top regression: pass");
		else
			$display("polygon_newell_normal_top regression: fail");
		$finish;
	end
endmodule
